// ----- hdl/fbc64_pkg.sv -----
package fbc64_pkg;

    localparam int BLOCK_W   = 64;
    localparam int WORD_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int SUBKEYS   = 12;
    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_AW   = $clog2(SBOX_DEPTH);
    localparam int ROUND_W   = 4;
    localparam int STEP_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int KEY_ROT   = 12;

    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'd1;

    // one round runs through five steps: four S-box reads per G, then the F mix
    localparam logic [STEP_W-1:0] STEP_0   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_1   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_2   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_3   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_MIX = 3'd4;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd15;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [SUBKEYS-1:0][BYTE_W-1:0] t_sk;

    typedef struct packed {
        logic                load;
        logic                adv;
        logic [STEP_W-1:0]   step;
        logic                we;
        logic [SBOX_AW-1:0]  waddr;
    } t_rctl;

    localparam t_byte SBOX [SBOX_DEPTH] = '{
        8'ha3, 8'hd7, 8'h09, 8'h83, 8'hf8, 8'h48, 8'hf6, 8'hf4,
        8'hb3, 8'h21, 8'h15, 8'h78, 8'h99, 8'hb1, 8'haf, 8'hf9,
        8'he7, 8'h2d, 8'h4d, 8'h8a, 8'hce, 8'h4c, 8'hca, 8'h2e,
        8'h52, 8'h95, 8'hd9, 8'h1e, 8'h4e, 8'h38, 8'h44, 8'h28,
        8'h0a, 8'hdf, 8'h02, 8'ha0, 8'h17, 8'hf1, 8'h60, 8'h68,
        8'h12, 8'hb7, 8'h7a, 8'hc3, 8'he9, 8'hfa, 8'h3d, 8'h53,
        8'h96, 8'h84, 8'h6b, 8'hba, 8'hf2, 8'h63, 8'h9a, 8'h19,
        8'h7c, 8'hae, 8'he5, 8'hf5, 8'hf7, 8'h16, 8'h6a, 8'ha2,
        8'h39, 8'hb6, 8'h7b, 8'h0f, 8'hc1, 8'h93, 8'h81, 8'h1b,
        8'hee, 8'hb4, 8'h1a, 8'hea, 8'hd0, 8'h91, 8'h2f, 8'hb8,
        8'h55, 8'hb9, 8'hda, 8'h85, 8'h3f, 8'h41, 8'hbf, 8'he0,
        8'h5a, 8'h58, 8'h80, 8'h5f, 8'h66, 8'h0b, 8'hd8, 8'h90,
        8'h35, 8'hd5, 8'hc0, 8'ha7, 8'h33, 8'h06, 8'h65, 8'h69,
        8'h45, 8'h00, 8'h94, 8'h56, 8'h6d, 8'h98, 8'h9b, 8'h76,
        8'h97, 8'hfc, 8'hb2, 8'hc2, 8'hb0, 8'hfe, 8'hdb, 8'h20,
        8'he1, 8'heb, 8'hd6, 8'he4, 8'hdd, 8'h47, 8'h4a, 8'h1d,
        8'h42, 8'hed, 8'h9e, 8'h6e, 8'h49, 8'h3c, 8'hcd, 8'h43,
        8'h27, 8'hd2, 8'h07, 8'hd4, 8'hde, 8'hc7, 8'h67, 8'h18,
        8'h89, 8'hcb, 8'h30, 8'h1f, 8'h8d, 8'hc6, 8'h8f, 8'haa,
        8'hc8, 8'h74, 8'hdc, 8'hc9, 8'h5d, 8'h5c, 8'h31, 8'ha4,
        8'h70, 8'h88, 8'h61, 8'h2c, 8'h9f, 8'h0d, 8'h2b, 8'h87,
        8'h50, 8'h82, 8'h54, 8'h64, 8'h26, 8'h7d, 8'h03, 8'h40,
        8'h34, 8'h4b, 8'h1c, 8'h73, 8'hd1, 8'hc4, 8'hfd, 8'h3b,
        8'hcc, 8'hfb, 8'h7f, 8'hab, 8'he6, 8'h3e, 8'h5b, 8'ha5,
        8'had, 8'h04, 8'h23, 8'h9c, 8'h14, 8'h51, 8'h22, 8'hf0,
        8'h29, 8'h79, 8'h71, 8'h7e, 8'hff, 8'h8c, 8'h0e, 8'he2,
        8'h0c, 8'hef, 8'hbc, 8'h72, 8'h75, 8'h6f, 8'h37, 8'ha1,
        8'hec, 8'hd3, 8'h8e, 8'h62, 8'h8b, 8'h86, 8'h10, 8'he8,
        8'h08, 8'h77, 8'h11, 8'hbe, 8'h92, 8'h4f, 8'h24, 8'hc5,
        8'h32, 8'h36, 8'h9d, 8'hcf, 8'hf3, 8'ha6, 8'hbb, 8'hac,
        8'h5e, 8'h6c, 8'ha9, 8'h13, 8'h57, 8'h25, 8'hb5, 8'he3,
        8'hbd, 8'ha8, 8'h3a, 8'h01, 8'h05, 8'h59, 8'h2a, 8'h46
    };

    // Subkeys of one round from the rolling key at the start of that round.
    // Encrypt: subkey i comes after i+1 left rotations; decrypt: after 11-i right ones.
    function automatic t_sk round_subkeys(input logic [BLOCK_W-1:0] rk, input logic dec,
                                          input logic round_lsb);
        t_sk                  sk;
        logic [BLOCK_W-1:0]   rot;
        logic [2:0]           bsel;
        for (int i = 0; i < SUBKEYS; i++) begin
            if (!dec) begin
                rot = (rk << (i + 1)) | (rk >> (BLOCK_W - 1 - i));
            end else begin
                rot = (rk >> (SUBKEYS - 1 - i)) | (rk << (BLOCK_W - SUBKEYS + 1 + i));
            end
            bsel  = {round_lsb ^ dec, 2'(i)};
            sk[i] = rot[{bsel, 3'b000} +: BYTE_W];
        end
        return sk;
    endfunction

endpackage

// ----- hdl/feistel_block_cipher_64.sv -----
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+-----------------------------------
// s_        | in        | s_tvalid / s_tready   | s_tdata[63:0] = block_in
// m_        | out       | m_tvalid / m_tready   | m_tdata[63:0] = block_out
// i_cfg_    | in        | i_cfg_we              | index 0 cipher_key, 1 decrypt_mode
//
// An item is loaded and whitened with the key, then run through 16 rounds.
// The round length is set by the four dependent S-box reads per G on the registered-read RAMs.
// After reset a fill pass writes all 256 S-box RAM entries; no item is taken until it ends.
// The result sits in an output register; a stalled output holds the last round.
// The next item is taken once the block is back to idle, even while a result waits.
module feistel_block_cipher_64 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbc64_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fbc64_pkg::BLOCK_W-1:0]   i_cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fbc64_pkg::BLOCK_W-1:0]   s_tdata,   // [63:0] block_in
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fbc64_pkg::BLOCK_W-1:0]   m_tdata    // [63:0] block_out
);
    import fbc64_pkg::*;

    localparam logic [1:0] ST_FILL = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [SBOX_AW-1:0] r_fill, n_fill;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [ROUND_W-1:0] r_round, n_round;
    logic               r_out_valid, n_out_valid;
    logic [BLOCK_W-1:0] r_out_data, n_out_data;
    logic [BLOCK_W-1:0] r_key;
    logic               r_dec;
    logic               w_out_free;
    t_rctl              w_ctl;
    t_sk                w_sk;
    logic [BLOCK_W-1:0] w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_dec <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CIPHER_KEY:   r_key <= i_cfg_data;
                REG_DECRYPT_MODE: r_dec <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || m_tready;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_step      = r_step;
        n_round     = r_round;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_ctl       = '{load: 1'b0, adv: 1'b0, step: r_step, we: 1'b0, waddr: r_fill};

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_FILL: begin
                w_ctl.we = 1'b1;
                n_fill   = r_fill + 1'b1;
                if (r_fill == SBOX_AW'(SBOX_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    w_ctl.load = 1'b1;
                    n_step     = STEP_0;
                    n_round    = '0;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step != STEP_MIX) begin
                    n_step = r_step + 1'b1;
                end else if (r_round != LAST_ROUND) begin
                    w_ctl.adv = 1'b1;
                    n_step    = STEP_0;
                    n_round   = r_round + 1'b1;
                end else if (w_out_free) begin
                    // hold in the mix step until the output register frees up
                    w_ctl.adv   = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = w_result ^ r_key;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_fill      <= '0;
            r_step      <= STEP_0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_step      <= n_step;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    fbc64_keysched u_keysched (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_key       (r_key),
        .i_dec       (r_dec),
        .i_round_lsb (r_round[0]),
        .o_sk        (w_sk)
    );

    fbc64_round u_round (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_block  (s_tdata),
        .i_key    (r_key),
        .i_dec    (r_dec),
        .i_sk     (w_sk),
        .o_result (w_result)
    );

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

// ----- hdl/fbc64_ram.sv -----
module fbc64_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/fbc64_keysched.sv -----
module fbc64_keysched (
    input  logic                         i_clk,
    input  fbc64_pkg::t_rctl             i_ctl,
    input  logic [fbc64_pkg::BLOCK_W-1:0] i_key,
    input  logic                         i_dec,
    input  logic                         i_round_lsb,
    output fbc64_pkg::t_sk               o_sk
);
    import fbc64_pkg::*;

    logic [BLOCK_W-1:0] r_rk;
    logic [BLOCK_W-1:0] n_rk;

    always_comb begin
        n_rk = r_rk;
        if (i_ctl.load) begin
            n_rk = i_key;
        end else if (i_ctl.adv) begin
            // a round consumes twelve one-bit rotations
            n_rk = i_dec ? {r_rk[KEY_ROT-1:0], r_rk[BLOCK_W-1:KEY_ROT]}
                         : {r_rk[BLOCK_W-KEY_ROT-1:0], r_rk[BLOCK_W-1:BLOCK_W-KEY_ROT]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rk <= n_rk;
    end

    assign o_sk = round_subkeys(r_rk, i_dec, i_round_lsb);

endmodule

// ----- hdl/fbc64_round.sv -----
module fbc64_round (
    input  logic                          i_clk,
    input  fbc64_pkg::t_rctl              i_ctl,
    input  logic [fbc64_pkg::BLOCK_W-1:0] i_block,
    input  logic [fbc64_pkg::BLOCK_W-1:0] i_key,
    input  logic                          i_dec,
    input  fbc64_pkg::t_sk                i_sk,
    output logic [fbc64_pkg::BLOCK_W-1:0] o_result
);
    import fbc64_pkg::*;

    logic [WORD_W-1:0] r_w [4];
    t_byte             r_c [2];
    t_byte             r_d [2];
    t_byte             r_e [2];
    t_byte             w_raddr [2];
    t_byte             w_rdata [2];
    logic [WORD_W-1:0] w_t [2];
    logic [WORD_W-1:0] w_f0, w_f1, w_n0, w_n1, w_x0, w_x1;
    logic [BLOCK_W-1:0] w_in;
    t_byte             w_wdata;

    assign w_wdata = SBOX[i_ctl.waddr];

    fbc64_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_ram_g0 (
        .i_clk   (i_clk),
        .i_we    (i_ctl.we),
        .i_waddr (i_ctl.waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[0]),
        .o_rdata (w_rdata[0])
    );

    fbc64_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_ram_g1 (
        .i_clk   (i_clk),
        .i_we    (i_ctl.we),
        .i_waddr (i_ctl.waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[1]),
        .o_rdata (w_rdata[1])
    );

    // G chains: word g uses subkeys 4g..4g+3
    always_comb begin
        for (int g = 0; g < 2; g++) begin
            unique case (i_ctl.step)
                STEP_0:  w_raddr[g] = r_w[g][7:0] ^ i_sk[4*g];
                STEP_1:  w_raddr[g] = w_rdata[g] ^ r_w[g][15:8] ^ i_sk[4*g+1];
                STEP_2:  w_raddr[g] = w_rdata[g] ^ r_w[g][7:0] ^ i_sk[4*g+2];
                STEP_3:  w_raddr[g] = w_rdata[g] ^ r_c[g] ^ i_sk[4*g+3];
                // repeat the last read so its data holds while the result waits
                default: w_raddr[g] = r_e[g] ^ i_sk[4*g+3];
            endcase
            w_t[g] = {r_e[g], w_rdata[g] ^ r_d[g]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 2; g++) begin
            unique case (i_ctl.step)
                STEP_1:  r_c[g] <= w_rdata[g] ^ r_w[g][15:8];
                STEP_2:  r_d[g] <= w_rdata[g] ^ r_w[g][7:0];
                STEP_3:  r_e[g] <= w_rdata[g] ^ r_c[g];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_f0 = w_t[0] + {w_t[1][WORD_W-2:0], 1'b0} + {i_sk[8], i_sk[9]};
        w_f1 = {w_t[0][WORD_W-2:0], 1'b0} + w_t[1] + {i_sk[10], i_sk[11]};
        w_x0 = r_w[2] ^ w_f0;
        w_x1 = r_w[3] ^ w_f1;
        if (!i_dec) begin
            w_n0 = {w_x0[0], w_x0[WORD_W-1:1]};
            w_n1 = {r_w[3][WORD_W-2:0], r_w[3][WORD_W-1]} ^ w_f1;
        end else begin
            w_n0 = {r_w[2][WORD_W-2:0], r_w[2][WORD_W-1]} ^ w_f0;
            w_n1 = {w_x1[0], w_x1[WORD_W-1:1]};
        end
    end

    assign w_in = i_block ^ i_key;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_w[0] <= w_in[63:48];
            r_w[1] <= w_in[47:32];
            r_w[2] <= w_in[31:16];
            r_w[3] <= w_in[15:0];
        end else if (i_ctl.adv) begin
            r_w[0] <= w_n0;
            r_w[1] <= w_n1;
            r_w[2] <= r_w[0];
            r_w[3] <= r_w[1];
        end
    end

    // block after the final round, halves already swapped
    assign o_result = {r_w[0], r_w[1], w_n0, w_n1};

endmodule
